@@ hdl/hsv_hsl_to_rgb_macros.svh @@
// Assertion macros shared by the color conversion RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef HSV_HSL_TO_RGB_MACROS_SVH
`define HSV_HSL_TO_RGB_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hsvrgb_pkg.sv @@
// Constants and types for the HSV/HSL to RGB conversion pipeline.
// Used by hsv_hsl_to_rgb; depends on nothing else.
package hsvrgb_pkg;

    // Number formats of the input word
    localparam int HUE_FRAC_BITS  = 4;
    localparam int UNIT_FRAC_BITS = 12;
    localparam int IN_W           = 13;
    localparam int OUT_W          = 8;

    localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;
    localparam int HUE_SECT = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
    localparam int NUM_SECT = 6;

    // Packed stream words
    localparam int IN_TDATA_W  = ((3 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    // Internal widths: chroma, doubled offset, sector fraction, products
    localparam int C_W  = 2 * UNIT_FRAC_BITS + 1;
    localparam int M2_W = 2 * UNIT_FRAC_BITS + 2;
    localparam int F_W  = $clog2(HUE_SECT + 1);
    localparam int P_W  = C_W + F_W;
    localparam int A_W  = P_W + 1;
    localparam int N_W  = A_W + OUT_W;

    // Divide by 2*ONE^2*SECT: SECT = 15 * 2^(HUE_FRAC_BITS+2)
    localparam int SECT_ODD   = 15;
    localparam int RND_SHIFT  = 2 * UNIT_FRAC_BITS + 1 + HUE_FRAC_BITS + 2;
    localparam int BYTE_MAX   = (1 << OUT_W) - 1;
    localparam int W_W        = 13;
    localparam int W_MAX      = BYTE_MAX * SECT_ODD + SECT_ODD / 2;
    localparam logic [N_W-1:0] RND_HALF = N_W'(SECT_ODD) << (RND_SHIFT - 1);

    // Reciprocal of 15, exact floor for dividends below 4681
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + SECT_ODD - 1) / SECT_ODD;
    localparam int Q_W         = 2 * W_W;

    // Pipeline depth
    localparam int NSTG = 7;

    typedef enum logic {
        MODE_HSV = 1'b0,
        MODE_HSL = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // Channel index within the per-channel arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

endpackage

@@ hdl/hsv_hsl_to_rgb.sv @@
// HSV/HSL to 8-bit RGB conversion, seven register stages.
// An accepted word passes through the stage 0 to stage 6 registers in order; o_m_tvalid is the stage 6 valid bit.
// Throughput: one word per cycle; a stall at the output backs up through the stage valid bits.
// Reset (synchronous, active low) clears the stage valid bits only; no state is kept.
// Depends on hsvrgb_pkg and hsv_hsl_to_rgb_macros.svh.
`include "hsv_hsl_to_rgb_macros.svh"

module hsv_hsl_to_rgb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [12:0] hue, [25:13] saturation, [38:26] brightness, [39] zero
    input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] command (0 HSV, 1 HSL)
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import hsvrgb_pkg::*;

    // Stage valid bits and advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] en;

    // Stage 0: clamped inputs, sector, multiplicand
    t_mode             r0_mode;
    t_sector           r0_sect;
    logic [F_W-1:0]    r0_rem;
    logic [IN_W-1:0]   r0_b;
    logic [IN_W-1:0]   r0_s;
    logic [IN_W-1:0]   r0_a;

    // Stage 1: chroma
    t_mode             r1_mode;
    t_sector           r1_sect;
    logic [F_W-1:0]    r1_rem;
    logic [IN_W-1:0]   r1_b;
    logic [C_W-1:0]    r1_c;

    // Stage 2: offset and per-channel sector fraction
    logic [C_W-1:0]            r2_c;
    logic [M2_W-1:0]           r2_m2;
    logic [2:0][F_W-1:0]       r2_f;

    // Stage 3: chroma share per channel
    logic [2:0][P_W-1:0]       r3_p;
    logic [M2_W-1:0]           r3_m2;

    // Stage 4: channel numerator
    logic [2:0][A_W-1:0]       r4_a;

    // Stage 5: scaled and rounded, still times 15
    logic [2:0][W_W-1:0]       r5_w;

    // Stage 6: output bytes
    logic [2:0][OUT_W-1:0]     r6_byte;

    // Input field split
    logic [IN_W-1:0] in_hue;
    logic [IN_W-1:0] in_sat;
    logic [IN_W-1:0] in_bri;

    assign in_hue = i_s_tdata[IN_W-1:0];
    assign in_sat = i_s_tdata[2*IN_W-1:IN_W];
    assign in_bri = i_s_tdata[3*IN_W-1:2*IN_W];

    // Build the enable chain from the output back
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    // Move valid bits one stage on each enable
    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 0 logic: clamp, find sector, pick chroma multiplicand
    logic [IN_W-1:0] s0_h;
    logic [IN_W-1:0] s0_s;
    logic [IN_W-1:0] s0_b;
    t_sector         s0_sect;
    logic [F_W-1:0]  s0_rem;
    logic [IN_W:0]   s0_twice;
    logic [IN_W:0]   s0_dist;
    logic [IN_W-1:0] s0_a;

    always_comb begin
        s0_h = (in_hue >= IN_W'(HUE_FULL)) ? '0 : in_hue;
        s0_s = (in_sat > IN_W'(UNIT_ONE)) ? IN_W'(UNIT_ONE) : in_sat;
        s0_b = (in_bri > IN_W'(UNIT_ONE)) ? IN_W'(UNIT_ONE) : in_bri;

        s0_sect = SEC_RED_YEL;
        s0_rem  = F_W'(s0_h);
        for (int k = 1; k < NUM_SECT; k++) begin
            if (s0_h >= IN_W'(k * HUE_SECT)) begin
                s0_sect = t_sector'(3'(k));
                s0_rem  = F_W'(s0_h - IN_W'(k * HUE_SECT));
            end
        end

        // HSL: 1 - |2L - 1|
        s0_twice = {s0_b, 1'b0};
        s0_dist  = (s0_twice >= (IN_W+1)'(UNIT_ONE)) ? s0_twice - (IN_W+1)'(UNIT_ONE)
                                                     : (IN_W+1)'(UNIT_ONE) - s0_twice;
        if (t_mode'(i_s_tuser) == MODE_HSL) begin
            s0_a = IN_W'((IN_W+1)'(UNIT_ONE) - s0_dist);
        end else begin
            s0_a = s0_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_mode <= t_mode'(i_s_tuser);
            r0_sect <= s0_sect;
            r0_rem  <= s0_rem;
            r0_b    <= s0_b;
            r0_s    <= s0_s;
            r0_a    <= s0_a;
        end
    end

    // Stage 1: chroma product
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mode <= r0_mode;
            r1_sect <= r0_sect;
            r1_rem  <= r0_rem;
            r1_b    <= r0_b;
            r1_c    <= C_W'(r0_a * r0_s);
        end
    end

    // Stage 2 logic: doubled offset and component order
    logic [M2_W-1:0]     s2_bz;
    logic [M2_W-1:0]     s2_cz;
    logic [M2_W-1:0]     s2_m2;
    logic [F_W-1:0]      s2_x;
    logic [2:0][F_W-1:0] s2_f;

    always_comb begin
        s2_bz = M2_W'(r1_b) << UNIT_FRAC_BITS;
        s2_cz = M2_W'(r1_c);
        if (r1_mode == MODE_HSL) begin
            s2_m2 = (s2_bz << 1) - s2_cz;
        end else begin
            s2_m2 = (s2_bz - s2_cz) << 1;
        end

        // Falling edge of the sector on odd sectors
        s2_x = r1_sect[0] ? F_W'(HUE_SECT) - r1_rem : r1_rem;

        s2_f = '0;
        case (r1_sect)
            SEC_RED_YEL: begin
                s2_f[CH_RED]   = F_W'(HUE_SECT);
                s2_f[CH_GREEN] = s2_x;
            end
            SEC_YEL_GRN: begin
                s2_f[CH_RED]   = s2_x;
                s2_f[CH_GREEN] = F_W'(HUE_SECT);
            end
            SEC_GRN_CYN: begin
                s2_f[CH_GREEN] = F_W'(HUE_SECT);
                s2_f[CH_BLUE]  = s2_x;
            end
            SEC_CYN_BLU: begin
                s2_f[CH_GREEN] = s2_x;
                s2_f[CH_BLUE]  = F_W'(HUE_SECT);
            end
            SEC_BLU_MAG: begin
                s2_f[CH_RED]   = s2_x;
                s2_f[CH_BLUE]  = F_W'(HUE_SECT);
            end
            default: begin
                s2_f[CH_RED]   = F_W'(HUE_SECT);
                s2_f[CH_BLUE]  = s2_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_c  <= r1_c;
            r2_m2 <= s2_m2;
            r2_f  <= s2_f;
        end
    end

    // Stage 3: chroma times sector fraction, per channel
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_m2 <= r2_m2;
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= P_W'(r2_c * r2_f[k]);
            end
        end
    end

    // Stage 4: add the offset scaled to the common denominator
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r4_a[k] <= (A_W'(r3_p[k]) << 1) + A_W'(A_W'(r3_m2) * A_W'(HUE_SECT));
            end
        end
    end

    // Stage 5: times 255, round half up, drop the power-of-two part
    logic [2:0][N_W-1:0] s5_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s5_n[k] = N_W'(N_W'(r4_a[k]) * N_W'(BYTE_MAX)) + RND_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r5_w[k] <= W_W'(s5_n[k] >> RND_SHIFT);
            end
        end
    end

    // Stage 6: divide by 15 through the reciprocal, clamp to a byte
    logic [2:0][Q_W-1:0]         s6_q;
    logic [2:0][Q_W-RECIP_SHIFT-1:0] s6_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s6_q[k] = Q_W'(r5_w[k] * W_W'(RECIP));
            s6_v[k] = s6_q[k][Q_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r6_byte[k] <= (s6_v[k] > (Q_W-RECIP_SHIFT)'(BYTE_MAX)) ? OUT_W'(BYTE_MAX)
                                                                       : OUT_W'(s6_v[k]);
            end
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = OUT_TDATA_W'({r6_byte[CH_BLUE], r6_byte[CH_GREEN], r6_byte[CH_RED]});

    // Checks on the pipeline control and the scaled range
    `HSVRGB_ASSERT_NEXT(a_accept_fills, i_s_tvalid && o_s_tready, r_vld[0], "accepted word lost at stage 0")
    `HSVRGB_ASSERT_NOW(a_ready_full, !o_s_tready, &r_vld, "input stalled with a bubble in the pipeline")
    `HSVRGB_ASSERT_NEXT(a_stall_keeps, r_vld[NSTG-2] && !en[NSTG-2], r_vld[NSTG-2], "stalled word dropped ahead of the output")
    `HSVRGB_ASSERT_NOW(a_w_range, r_vld[5], (r5_w[CH_RED] <= W_W'(W_MAX)) && (r5_w[CH_GREEN] <= W_W'(W_MAX)) && (r5_w[CH_BLUE] <= W_W'(W_MAX)), "scaled channel above full scale")

endmodule
